// ===== hdl/vzrd_pkg.sv =====
// vzrd_pkg: shared widths, register indexes, mode codes and the result type
// of the visibility zero-run decoder. No dependencies.
package vzrd_pkg;

    localparam int LEAF_CNT_W = 14;  // leaf_count register
    localparam int LEAF_W     = 13;  // leaf indexes on registers and results
    localparam int MODE_W     = 2;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;  // widest register

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEAF_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_LEAF    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DECODE_MODE = 2'd2;

    // decode_mode codes
    localparam logic [MODE_W-1:0] MODE_DECODE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ALL_VIS = 2'd1;
    localparam logic [MODE_W-1:0] MODE_NONE    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_BAD     = 2'd3;

    typedef struct packed {
        logic [LEAF_W-1:0] first_leaf;
        logic [BYTE_W-1:0] visible_mask;
        logic              is_final;
        logic              all_visible;
    } t_res;

endpackage

// ===== hdl/visibility_zero_run_decoder.sv =====
// visibility_zero_run_decoder: run-length visibility decoder, one compressed
// byte per word in, literal masks and a closing word out.
// Depends on vzrd_pkg.
//
//  channel | direction | handshake                    | payload
//  --------+-----------+------------------------------+----------------------------------
//  input   | in        | i_in_valid / o_in_ready      | i_data_byte, i_end_of_data
//  output  | out       | o_out_valid / i_out_ready    | o_first_leaf, o_visible_mask,
//          |           |                              | o_is_final, o_all_visible
//  config  | in        | i_cfg_we (no wait)           | i_cfg_index, i_cfg_data
//
// Flow: one input word per cycle while the result queue has room; a word is held
//   in the input register, and its results are written from there into a
//   2-entry result queue whose head drives the output.
// A word with two results (literal plus closing word) needs both queue entries free.
// Stalls: a word waits in the input register until the queue has room for its results.
// Reset (synchronous, active low) clears registers, decode state and queue.
module visibility_zero_run_decoder #(
    parameter int MAX_LEAVES = 8192
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // config write port
    input  logic                            i_cfg_we,
    input  logic [vzrd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [vzrd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [vzrd_pkg::BYTE_W-1:0]     i_data_byte,
    input  logic                            i_end_of_data,
    // output channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [vzrd_pkg::LEAF_W-1:0]     o_first_leaf,
    output logic [vzrd_pkg::BYTE_W-1:0]     o_visible_mask,
    output logic                            o_is_final,
    output logic                            o_all_visible
);
    import vzrd_pkg::*;

    // Width of the effective leaf count (leaf_count clipped to MAX_LEAVES).
    localparam int MAXL_W = $clog2(MAX_LEAVES + 1);
    localparam int CMP_W  = (MAXL_W > LEAF_CNT_W) ? MAXL_W : LEAF_CNT_W;
    // Wide working width for byte offsets and leaf arithmetic.
    localparam int AW     = CMP_W + 4;
    // Byte position spans 0 .. bitmap byte count.
    localparam int NBYTES_MAX = (MAX_LEAVES + 6) / 8;
    localparam int PW     = $clog2(NBYTES_MAX + 1);

    localparam logic [CMP_W-1:0] MAX_LEAVES_C = CMP_W'(MAX_LEAVES);

    // ---------------- configuration registers ----------------
    logic [LEAF_CNT_W-1:0] r_leaf_count;
    logic [LEAF_W-1:0]     r_own_leaf;
    logic [MODE_W-1:0]     r_decode_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leaf_count  <= '0;
            r_own_leaf    <= '0;
            r_decode_mode <= MODE_DECODE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_LEAF_COUNT:  r_leaf_count  <= i_cfg_data[LEAF_CNT_W-1:0];
                REG_OWN_LEAF:    r_own_leaf    <= i_cfg_data[LEAF_W-1:0];
                REG_DECODE_MODE: r_decode_mode <= i_cfg_data[MODE_W-1:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // ---------------- input register ----------------
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_data;
    logic              r_last;
    logic              commit;      // registered word's results go to the queue

    assign o_in_ready = !r_in_valid || commit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_data <= i_data_byte;
            r_last <= i_end_of_data;
        end
    end

    // ---------------- decode state ----------------
    logic [PW-1:0] r_pos, n_pos;   // bitmap bytes covered so far
    logic          r_run, n_run;   // previous byte was a zero-run marker
    logic          r_fin, n_fin;   // closing word already sent for this stream

    // ---------------- decode logic ----------------
    logic [CMP_W-1:0]  leaves;
    logic              bad_own;
    logic [MODE_W-1:0] mode;
    logic [AW-1:0]     vis, nbytes, pos_w, pos_sum, base;
    logic [BYTE_W-1:0] keep;
    logic [1:0]        n_push;
    t_res              res_a, res_b;
    t_res              lit_res, fin_res;

    always_comb begin
        leaves  = (CMP_W'(r_leaf_count) > MAX_LEAVES_C) ? MAX_LEAVES_C
                                                        : CMP_W'(r_leaf_count);
        bad_own = (r_own_leaf == '0) || (CMP_W'(r_own_leaf) >= leaves);
        mode    = (bad_own || r_decode_mode == MODE_BAD) ? MODE_NONE : r_decode_mode;

        // visible leaves exclude void leaf 0; bitmap is ceil(vis/8) bytes
        vis     = AW'(leaves) - AW'(1);
        nbytes  = (AW'(leaves) + AW'(6)) >> 3;
        base    = AW'(r_pos) << 3;
        pos_sum = AW'(r_pos) + AW'(r_data);

        for (int b = 0; b < BYTE_W; b++) begin
            keep[b] = (base + AW'(b)) < vis;
        end

        lit_res.first_leaf   = LEAF_W'(base + AW'(1));
        lit_res.visible_mask = r_data & keep;
        lit_res.is_final     = 1'b0;
        lit_res.all_visible  = 1'b0;

        fin_res.first_leaf   = r_own_leaf;
        fin_res.visible_mask = BYTE_W'(1);
        fin_res.is_final     = 1'b1;
        fin_res.all_visible  = 1'b0;

        res_a  = fin_res;
        res_b  = fin_res;
        n_push = 2'd0;
        n_pos  = r_pos;
        n_run  = r_run;
        n_fin  = r_fin;
        pos_w  = AW'(r_pos);

        if (!r_fin) begin
            if (mode != MODE_DECODE) begin
                // all-visible or nothing-visible: one closing word per stream
                res_a.first_leaf   = '0;
                res_a.visible_mask = '0;
                res_a.all_visible  = (mode == MODE_ALL_VIS);
                n_push             = 2'd1;
                n_fin              = 1'b1;
            end else begin
                priority if (r_run) begin
                    // run length byte, saturate at bitmap end
                    pos_w = (pos_sum > nbytes) ? nbytes : pos_sum;
                    n_run = 1'b0;
                end else if (r_data == '0) begin
                    n_run = 1'b1;
                end else begin
                    res_a  = lit_res;
                    n_push = 2'd1;
                    pos_w  = AW'(r_pos) + AW'(1);
                end
                if (pos_w >= nbytes || r_last) begin
                    n_push = n_push + 2'd1;   // closing word goes after any literal
                    n_fin  = 1'b1;
                end
                n_pos = PW'(pos_w);
            end
        end

        if (r_last) begin
            n_pos = '0;
            n_run = 1'b0;
            n_fin = 1'b0;
        end
    end

    // ---------------- result queue (2 entries, head in r_q0) ----------------
    t_res       r_q0, r_q1, n_q0, n_q1;
    logic [1:0] r_cnt, n_cnt, cnt_ap, free;
    logic       pop;

    assign pop    = o_out_valid && i_out_ready;
    assign cnt_ap = r_cnt - {1'b0, pop};
    assign free   = 2'd2 - cnt_ap;
    assign commit = r_in_valid && (n_push <= free);

    always_comb begin
        n_q0 = pop ? r_q1 : r_q0;
        n_q1 = r_q1;
        if (commit && n_push != 2'd0) begin
            if (cnt_ap == 2'd0) begin
                n_q0 = res_a;
            end else begin
                n_q1 = res_a;
            end
            if (n_push == 2'd2) begin
                n_q1 = res_b;
            end
        end
        n_cnt = cnt_ap + (commit ? n_push : 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_pos <= '0;
            r_run <= 1'b0;
            r_fin <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (commit) begin
                r_pos <= n_pos;
                r_run <= n_run;
                r_fin <= n_fin;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

    assign o_out_valid    = (r_cnt != 2'd0);
    assign o_first_leaf   = r_q0.first_leaf;
    assign o_visible_mask = r_q0.visible_mask;
    assign o_is_final     = r_q0.is_final;
    assign o_all_visible  = r_q0.all_visible;

    // ---------------- assertions ----------------
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result queue count out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |-> (cnt_ap + n_push) <= 2'd2)
        else $error("result queue overflow");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && r_last) |=> (r_pos == '0 && !r_run && !r_fin))
        else $error("decoder did not restart after end of data");

    a_finished_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_fin) |-> n_push == 2'd0)
        else $error("result produced after closing word");

endmodule
